[rtl/core/celsius_fahrenheit_converter_core_defines.svh]
// ----------------------------------------------------------------------------
// Converter assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef CELSIUS_FAHRENHEIT_CONVERTER_CORE_DEFINES_SVH
`define CELSIUS_FAHRENHEIT_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CFC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/cfc_pkg.sv]
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared widths, types and constant tables of the temperature converter.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_W     = 8;
  localparam int SCALE_W    = 7;
  localparam int VALUE_W    = 16;
  localparam int RESULT_W   = 17;
  localparam int NUM_W      = 21;
  localparam int MAG_W      = NUM_W - 1;
  localparam int REM_W      = 5;
  localparam int RECIP_SH   = 21;
  localparam int RECIP_W    = 20;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [PADDR_W-3:0] REG_DISPLAY = '0;

  localparam logic [RECIP_W-1:0] RECIP_3  = RECIP_W'((1 << RECIP_SH) / 3);
  localparam logic [RECIP_W-1:0] RECIP_5  = RECIP_W'((1 << RECIP_SH) / 5);
  localparam logic [RECIP_W-1:0] RECIP_9  = RECIP_W'((1 << RECIP_SH) / 9);
  localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'((1 << RECIP_SH) / 10);
  localparam logic [RECIP_W-1:0] RECIP_18 = RECIP_W'((1 << RECIP_SH) / 18);

  typedef logic signed [NUM_W-1:0]    num_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [REM_W-1:0]           rem_t;
  typedef logic signed [RESULT_W-1:0] res_t;

  localparam num_t CACHE_TOL = num_t'(2);

  typedef enum logic [2:0] {
    DIV_3,
    DIV_5,
    DIV_9,
    DIV_10,
    DIV_18
  } div_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    P_CF1,
    P_CF_RND,
    P_CF_TEN,
    P_CF_LIN,
    P_FC1,
    P_FC_RND,
    P_FC_LIN
  } path_t;

  typedef struct packed {
    logic     go;
    div_sel_t sel;
    num_t     num;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic neg;
    num_t quot;
    rem_t rem;
  } div_rsp_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    res_t               data;
  } cache_wr_t;

  function automatic logic [RECIP_W-1:0] div_recip(input div_sel_t sel);
    logic [RECIP_W-1:0] r;
    unique case (sel)
      DIV_3:   r = RECIP_3;
      DIV_5:   r = RECIP_5;
      DIV_9:   r = RECIP_9;
      DIV_10:  r = RECIP_10;
      DIV_18:  r = RECIP_18;
      default: r = RECIP_10;
    endcase
    return r;
  endfunction

  function automatic rem_t div_const(input div_sel_t sel);
    rem_t d;
    unique case (sel)
      DIV_3:   d = rem_t'(3);
      DIV_5:   d = rem_t'(5);
      DIV_9:   d = rem_t'(9);
      DIV_10:  d = rem_t'(10);
      DIV_18:  d = rem_t'(18);
      default: d = rem_t'(10);
    endcase
    return d;
  endfunction

  // correction of the Fahrenheit input by its residue mod 9
  function automatic logic signed [3:0] f_fix(input logic [3:0] k);
    logic signed [3:0] f;
    case (k)
      4'd0:    f = 4'sd0;
      4'd1:    f = -4'sd1;
      4'd2:    f = -4'sd2;
      4'd3:    f = -4'sd3;
      4'd4:    f = -4'sd4;
      4'd5:    f = 4'sd4;
      4'd6:    f = 4'sd3;
      4'd7:    f = 4'sd2;
      4'd8:    f = 4'sd1;
      default: f = 4'sd0;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/cfc_cache.sv]
// ----------------------------------------------------------------------------
// cfc_cache
// Per-slot Fahrenheit cache: synchronous RAM with registered read and
// reset-cleared valid bits.
// ----------------------------------------------------------------------------
module cfc_cache (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [cfc_pkg::SLOT_AW-1:0]  rd_addr,
  output cfc_pkg::res_t                rd_data,
  output logic                         rd_valid,
  input  cfc_pkg::cache_wr_t           wr
);

  cfc_pkg::res_t                 mem [cfc_pkg::SLOT_COUNT];
  logic [cfc_pkg::SLOT_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

endmodule

[rtl/core/cfc_cdiv.sv]
// ----------------------------------------------------------------------------
// cfc_cdiv
// Signed division by a small constant (3, 5, 9, 10, 18), truncating toward
// zero. Three stages: magnitude, reciprocal multiply, one-step correction.
// ----------------------------------------------------------------------------
module cfc_cdiv (
  input  logic              clk,
  input  logic              rst,
  input  cfc_pkg::div_req_t req,
  output cfc_pkg::div_rsp_t rsp
);

  localparam int PROD_W = cfc_pkg::MAG_W + cfc_pkg::RECIP_W;
  localparam int QD_W   = cfc_pkg::MAG_W + 5;

  logic                vld_a;
  logic                vld_b;
  logic                neg_a;
  logic                neg_b;
  cfc_pkg::div_sel_t   sel_a;
  cfc_pkg::div_sel_t   sel_b;
  cfc_pkg::mag_t       mag_a;
  cfc_pkg::mag_t       mag_b;
  cfc_pkg::mag_t       qest_b;
  logic [PROD_W-1:0]   prod;
  logic [QD_W-1:0]     qx;
  logic [QD_W-1:0]     qd;
  cfc_pkg::mag_t       rtmp;
  cfc_pkg::mag_t       dv;
  cfc_pkg::mag_t       qfin;
  cfc_pkg::mag_t       rfin;
  logic                done_c;
  logic                neg_c;
  cfc_pkg::num_t       quot_c;
  cfc_pkg::rem_t       rem_c;
  cfc_pkg::num_t       qnum;

  assign prod = {{cfc_pkg::RECIP_W{1'b0}}, mag_a} *
                {{cfc_pkg::MAG_W{1'b0}}, cfc_pkg::div_recip(sel_a)};

  always_comb begin
    qx = {5'b0, qest_b};
    case (sel_b)
      cfc_pkg::DIV_3:  qd = (qx << 1) + qx;
      cfc_pkg::DIV_5:  qd = (qx << 2) + qx;
      cfc_pkg::DIV_9:  qd = (qx << 3) + qx;
      cfc_pkg::DIV_10: qd = (qx << 3) + (qx << 1);
      cfc_pkg::DIV_18: qd = (qx << 4) + (qx << 1);
      default:         qd = (qx << 3) + (qx << 1);
    endcase
    rtmp = cfc_pkg::MAG_W'({5'b0, mag_b} - qd);
    dv   = cfc_pkg::MAG_W'(cfc_pkg::div_const(sel_b));
    if (rtmp >= dv) begin
      qfin = qest_b + cfc_pkg::MAG_W'(1);
      rfin = rtmp - dv;
    end else begin
      qfin = qest_b;
      rfin = rtmp;
    end
    qnum = cfc_pkg::num_t'({1'b0, qfin});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a  <= 1'b0;
      vld_b  <= 1'b0;
      done_c <= 1'b0;
    end else begin
      vld_a  <= req.go;
      vld_b  <= vld_a;
      done_c <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      neg_a <= req.num[cfc_pkg::NUM_W-1];
      sel_a <= req.sel;
      mag_a <= req.num[cfc_pkg::NUM_W-1] ? cfc_pkg::MAG_W'(-req.num)
                                          : cfc_pkg::MAG_W'(req.num);
    end
    if (vld_a) begin
      neg_b  <= neg_a;
      sel_b  <= sel_a;
      mag_b  <= mag_a;
      qest_b <= cfc_pkg::MAG_W'(prod >> cfc_pkg::RECIP_SH);
    end
    if (vld_b) begin
      neg_c  <= neg_b;
      quot_c <= neg_b ? -qnum : qnum;
      rem_c  <= cfc_pkg::REM_W'(rfin);
    end
  end

  assign rsp = '{done: done_c, neg: neg_c, quot: quot_c, rem: rem_c};

endmodule

[rtl/core/celsius_fahrenheit_converter_core.sv]
// ----------------------------------------------------------------------------
// celsius_fahrenheit_converter_core: scaled Celsius/Fahrenheit converter
// Pass-through, difference and error items go from decode straight to done;
// the others run one, two or three constant divisions by scale and direction.
// A new item is taken in the done cycle; all divisions use the shared 3-stage divider.
// Sync reset clears the control state, display register and cache valid bits.
// ----------------------------------------------------------------------------
`include "celsius_fahrenheit_converter_core_defines.svh"

module celsius_fahrenheit_converter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [cfc_pkg::SCALE_W-1:0]         scale,
  input  logic signed [cfc_pkg::VALUE_W-1:0]  value,
  input  logic                                is_difference,
  input  logic                                slot_present,
  input  logic [cfc_pkg::SLOT_W-1:0]          slot,
  output logic                                done,
  output logic signed [cfc_pkg::RESULT_W-1:0] result,
  output logic                                error,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cfc_pkg::PADDR_W-1:0]         paddr,
  input  logic [cfc_pkg::PDATA_W-1:0]         pwdata,
  output logic [cfc_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  cfc_pkg::state_t                    state;
  cfc_pkg::state_t                    state_next;
  logic [1:0]                         step;
  logic [1:0]                         step_next;
  logic                               fahrenheit_display;
  logic                               accept;
  logic                               mode_q;
  logic [cfc_pkg::SCALE_W-1:0]        scale_q;
  logic signed [cfc_pkg::VALUE_W-1:0] value_q;
  logic                               diff_q;
  logic                               present_q;
  logic [cfc_pkg::SLOT_W-1:0]         slot_q;
  logic [cfc_pkg::SCALE_W-1:0]        s_eff;
  logic [3:0]                         s_rnd;
  logic                               slot_cached;
  logic                               trivial;
  logic                               finish;
  logic                               res_load;
  cfc_pkg::path_t                     path;
  cfc_pkg::res_t                      res_q;
  cfc_pkg::res_t                      res_next;
  logic                               err_q;
  logic                               err_next;
  cfc_pkg::res_t                      cache_rd;
  logic                               cache_vld;
  cfc_pkg::cache_wr_t                 cache_wr;
  cfc_pkg::div_req_t                  div_req;
  cfc_pkg::div_rsp_t                  div_rsp;

  function automatic cfc_pkg::num_t mul10(input cfc_pkg::num_t x);
    return (x <<< 3) + (x <<< 1);
  endfunction

  function automatic cfc_pkg::num_t mul18(input cfc_pkg::num_t x);
    return (x <<< 4) + (x <<< 1);
  endfunction

  function automatic cfc_pkg::num_t mul320(input cfc_pkg::num_t x);
    return (x <<< 8) + (x <<< 6);
  endfunction

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[cfc_pkg::PADDR_W-1:2] == cfc_pkg::REG_DISPLAY)
                  ? {{(cfc_pkg::PDATA_W-1){1'b0}}, fahrenheit_display} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fahrenheit_display <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[cfc_pkg::PADDR_W-1:2] == cfc_pkg::REG_DISPLAY) begin
      fahrenheit_display <= pwdata[0];
    end
  end

  // handshake
  assign busy   = (state == cfc_pkg::ST_DECODE) || (state == cfc_pkg::ST_DIV);
  assign accept = start && !busy;
  assign done   = (state == cfc_pkg::ST_DONE);
  assign result = res_q;
  assign error  = err_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q    <= mode;
      scale_q   <= scale;
      value_q   <= value;
      diff_q    <= is_difference;
      present_q <= slot_present;
      slot_q    <= slot;
    end
    if (res_load) begin
      res_q <= res_next;
      err_q <= err_next;
    end
  end

  cfc_cache u_cache (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (slot[cfc_pkg::SLOT_AW-1:0]),
    .rd_data  (cache_rd),
    .rd_valid (cache_vld),
    .wr       (cache_wr)
  );

  cfc_cdiv u_cdiv (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // decode of the held item
  assign s_eff       = (scale_q == '0) ? cfc_pkg::SCALE_W'(1) : scale_q;
  assign s_rnd       = (s_eff == cfc_pkg::SCALE_W'(5)) ? 4'd10 : s_eff[3:0];
  assign slot_cached = {1'b0, slot_q} < 9'(cfc_pkg::SLOT_COUNT);
  assign trivial     = !fahrenheit_display || diff_q ||
                       (s_eff == cfc_pkg::SCALE_W'(1) && !present_q);

  always_comb begin
    if (mode_q) begin
      if (s_eff == cfc_pkg::SCALE_W'(1))      path = cfc_pkg::P_CF1;
      else if (s_eff == cfc_pkg::SCALE_W'(5)) path = cfc_pkg::P_CF_TEN;
      else if (s_eff < cfc_pkg::SCALE_W'(5))  path = cfc_pkg::P_CF_RND;
      else                                    path = cfc_pkg::P_CF_LIN;
    end else begin
      if (s_eff == cfc_pkg::SCALE_W'(1))      path = cfc_pkg::P_FC1;
      else if (s_eff <= cfc_pkg::SCALE_W'(5)) path = cfc_pkg::P_FC_RND;
      else                                    path = cfc_pkg::P_FC_LIN;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cfc_pkg::ST_IDLE: begin
        if (start) state_next = cfc_pkg::ST_DECODE;
      end
      cfc_pkg::ST_DECODE: begin
        state_next = trivial ? cfc_pkg::ST_DONE : cfc_pkg::ST_DIV;
      end
      cfc_pkg::ST_DIV: begin
        if (finish) state_next = cfc_pkg::ST_DONE;
      end
      cfc_pkg::ST_DONE: begin
        state_next = start ? cfc_pkg::ST_DECODE : cfc_pkg::ST_IDLE;
      end
      default: state_next = cfc_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cfc_pkg::num_t v;
    cfc_pkg::num_t sx;
    cfc_pkg::num_t srx;
    cfc_pkg::num_t x;
    cfc_pkg::num_t calc;
    cfc_pkg::num_t dlt;
    cfc_pkg::num_t fixs;
    logic [3:0]    k;
    logic [1:0]    shamt;
    v     = cfc_pkg::num_t'(value_q);
    sx    = cfc_pkg::num_t'(s_eff);
    srx   = cfc_pkg::num_t'(s_rnd);
    x     = v - (srx <<< 5);
    calc  = '0;
    dlt   = '0;
    fixs  = '0;
    k     = '0;
    shamt = (s_rnd == 4'd2) ? 2'd1 : 2'd2;
    div_req   = '{go: 1'b0, sel: cfc_pkg::DIV_10, num: '0};
    cache_wr  = '{en: 1'b0, addr: slot_q[cfc_pkg::SLOT_AW-1:0],
                  data: cfc_pkg::res_t'(value_q)};
    res_next  = res_q;
    err_next  = 1'b0;
    res_load  = 1'b0;
    finish    = 1'b0;
    step_next = step;
    unique case (state)
      cfc_pkg::ST_DECODE: begin
        if (trivial) begin
          res_load = 1'b1;
          if (!fahrenheit_display) begin
            res_next = cfc_pkg::res_t'(value_q);
          end else if (diff_q) begin
            if (mode_q) res_next = cfc_pkg::res_t'(value_q) <<< 1;
            else        res_next = cfc_pkg::res_t'(v + cfc_pkg::num_t'(value_q < 0)) >>> 1;
          end else begin
            res_next = '0;
            err_next = 1'b1;
          end
        end else begin
          div_req.go = 1'b1;
          step_next  = 2'd0;
          case (path)
            cfc_pkg::P_CF1: begin
              div_req.num = (v < -cfc_pkg::num_t'(18)) ? mul18(v) - cfc_pkg::num_t'(5)
                                                      : mul18(v) + cfc_pkg::num_t'(5);
            end
            cfc_pkg::P_CF_RND, cfc_pkg::P_CF_TEN: begin
              div_req.num = (v < -mul18(srx)) ? mul18(v) - ((srx <<< 2) + srx)
                                              : mul18(v) + ((srx <<< 2) + srx);
            end
            cfc_pkg::P_CF_LIN: begin
              div_req.sel = cfc_pkg::DIV_5;
              div_req.num = (v <<< 3) + v;
            end
            cfc_pkg::P_FC1: begin
              div_req.sel = cfc_pkg::DIV_18;
              div_req.num = (v < cfc_pkg::num_t'(32))
                            ? mul10(v - cfc_pkg::num_t'(32)) - cfc_pkg::num_t'(9)
                            : mul10(v - cfc_pkg::num_t'(32)) + cfc_pkg::num_t'(9);
              cache_wr.en = present_q && slot_cached;
            end
            cfc_pkg::P_FC_RND: begin
              if (s_rnd == 4'd3 || s_rnd == 4'd10) begin
                div_req.sel = (s_rnd == 4'd3) ? cfc_pkg::DIV_3 : cfc_pkg::DIV_10;
                div_req.num = x;
              end else begin
                div_req.sel = cfc_pkg::DIV_9;
                div_req.num = x[cfc_pkg::NUM_W-1] ? -((-x) >>> shamt) : (x >>> shamt);
                step_next   = 2'd1;
              end
            end
            default: begin
              div_req.sel = cfc_pkg::DIV_18;
              div_req.num = mul10(v) - mul320(sx);
            end
          endcase
        end
      end
      cfc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          case (path)
            cfc_pkg::P_CF1: begin
              finish   = 1'b1;
              calc     = div_rsp.quot + cfc_pkg::num_t'(32);
              dlt      = calc - cfc_pkg::num_t'(cache_rd);
              res_next = cfc_pkg::res_t'(calc);
              cache_wr.data = cfc_pkg::res_t'(calc);
              if (slot_cached) begin
                if (cache_vld && dlt <= cfc_pkg::CACHE_TOL && dlt >= -cfc_pkg::CACHE_TOL) begin
                  res_next = cache_rd;
                end else begin
                  cache_wr.en = 1'b1;
                end
              end
            end
            cfc_pkg::P_CF_RND: begin
              finish   = 1'b1;
              res_next = cfc_pkg::res_t'(div_rsp.quot + (srx <<< 5));
            end
            cfc_pkg::P_CF_TEN: begin
              if (step == 2'd0) begin
                div_req.go  = 1'b1;
                div_req.num = div_rsp.quot + cfc_pkg::num_t'(320);
                step_next   = 2'd1;
              end else begin
                finish   = 1'b1;
                res_next = cfc_pkg::res_t'(mul10(div_rsp.quot));
              end
            end
            cfc_pkg::P_CF_LIN: begin
              finish   = 1'b1;
              res_next = cfc_pkg::res_t'(div_rsp.quot + (sx <<< 5));
            end
            cfc_pkg::P_FC_RND: begin
              if (step == 2'd0) begin
                div_req.go  = 1'b1;
                div_req.sel = cfc_pkg::DIV_9;
                div_req.num = div_rsp.quot;
                step_next   = 2'd1;
              end else if (step == 2'd1) begin
                // C-style remainder wrapped into 0..8
                k = (div_rsp.neg && div_rsp.rem != '0) ? 4'(5'd9 - div_rsp.rem)
                                                      : div_rsp.rem[3:0];
                fixs        = cfc_pkg::num_t'(cfc_pkg::f_fix(k)) * srx;
                div_req.go  = 1'b1;
                div_req.sel = cfc_pkg::DIV_18;
                div_req.num = mul10(v) + fixs - mul320(srx);
                step_next   = 2'd2;
              end else begin
                finish   = 1'b1;
                res_next = cfc_pkg::res_t'(div_rsp.quot);
              end
            end
            default: begin
              finish   = 1'b1;
              res_next = cfc_pkg::res_t'(div_rsp.quot);
            end
          endcase
          res_load = finish;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfc_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  `CFC_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `CFC_ASSERT_IMPL(a_error_zero, clk, rst, done && error, result == '0)
  `CFC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `CFC_ASSERT_IMPL(a_div_in_state, clk, rst, div_rsp.done, state == cfc_pkg::ST_DIV)

endmodule
